// ===== rtl/swcc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Simpson weighted complex correlator.
// Holds payload structs, widths, register indexes and the 48-bit saturation helper.
// No dependencies.
package swcc_pkg;

  localparam int SampleBits = 16;
  localparam int MaxSamples = 4096;
  localparam int CountW     = 13;
  localparam int StepW      = 16;
  localparam int AccW       = 48;
  localparam int ProdW      = 2 * SampleBits;
  localparam int WProdW     = ProdW + 3;
  localparam int CfgDataW   = (CountW > StepW) ? CountW : StepW;

  localparam logic [CountW-1:0] MinCount = CountW'(3);
  localparam logic [CountW-1:0] MaxCount =
    (MaxSamples >= (1 << CountW)) ? {CountW{1'b1}} : CountW'(MaxSamples);
  localparam logic [CountW-1:0] CountReset = CountW'(4096);
  localparam logic [StepW-1:0]  StepReset  = StepW'(655);

  localparam logic CfgSampleCount = 1'b0;
  localparam logic CfgStepSize    = 1'b1;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_value;
    logic signed [SampleBits-1:0] wavelet_real;
    logic signed [SampleBits-1:0] wavelet_imag;
  } item_t;

  typedef struct packed {
    logic signed [AccW-1:0] integral_real;
    logic signed [AccW-1:0] integral_imag;
  } result_t;

  function automatic logic signed [AccW-1:0] sat48(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/swcc_finish.sv =====
`timescale 1ns / 1ps
// Scaling pipeline for one part of the integral: h/3 on the Simpson sum, 3h/8 on the tail
// sum, signed combine and saturation. Seven stages, all advanced by one enable.
// Depends on swcc_pkg.
module swcc_finish
  import swcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AccW-1:0] s_sum,
  input  logic signed [AccW-1:0] t_sum,
  input  logic [StepW-1:0]       step,
  output logic signed [AccW-1:0] result
);

  localparam logic [14:0] Recip3 = 15'd21846;

  // one 12-bit digit of a divide by three: returns {quotient, remainder}
  function automatic logic [13:0] div3_step(input logic [1:0] r, input logic [11:0] c);
    logic [13:0] v;
    logic [28:0] prod;
    logic [11:0] q;
    logic [13:0] rem;
    v    = {r, c};
    prod = 29'(v) * 29'(Recip3);
    q    = prod[27:16];
    rem  = v - 14'(3 * q);
    return {q, rem[1:0]};
  endfunction

  logic [4:0]        s_neg, t_neg;
  logic [AccW-1:0]   s_abs, t_abs;
  logic [39:0]       s_ph, s_pl, t_ph, t_pl;
  logic [63:0]       ms, mt;
  logic [23:0]       q_hi;
  logic [1:0]        q_rem;
  logic [23:0]       u_lo;
  logic [AccW-1:0]   b_mag4, b_mag5;
  logic [AccW-1:0]   a_mag;
  logic signed [AccW:0] a_val, b_val;

  logic [47:0] u;
  logic [44:0] mt_hi;
  logic [20:0] mt_lo3;
  logic [13:0] d3, d2, d1, d0;

  always_comb begin
    u      = ms[63:16];
    mt_hi  = mt[63:19];
    mt_lo3 = 21'(3 * 21'(mt[18:0]));
    d3     = div3_step(2'b00, u[47:36]);
    d2     = div3_step(d3[1:0], u[35:24]);
    d1     = div3_step(q_rem, u_lo[23:12]);
    d0     = div3_step(d1[1:0], u_lo[11:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_neg  <= {s_neg[3:0], s_sum[AccW-1]};
      t_neg  <= {t_neg[3:0], t_sum[AccW-1]};
      s_abs  <= s_sum[AccW-1] ? AccW'(-s_sum) : AccW'(s_sum);
      t_abs  <= t_sum[AccW-1] ? AccW'(-t_sum) : AccW'(t_sum);

      s_ph   <= 40'(s_abs[47:24]) * 40'(step);
      s_pl   <= 40'(s_abs[23:0]) * 40'(step);
      t_ph   <= 40'(t_abs[47:24]) * 40'(step);
      t_pl   <= 40'(t_abs[23:0]) * 40'(step);

      ms     <= {s_ph, 24'b0} + 64'(s_pl);
      mt     <= {t_ph, 24'b0} + 64'(t_pl);

      q_hi   <= {d3[13:2], d2[13:2]};
      q_rem  <= d2[1:0];
      u_lo   <= u[23:0];
      b_mag4 <= AccW'({mt_hi, 1'b0}) + AccW'(mt_hi) + AccW'(mt_lo3[20:19]);

      a_mag  <= {q_hi, d1[13:2], d0[13:2]};
      b_mag5 <= b_mag4;

      a_val  <= s_neg[4] ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
      b_val  <= t_neg[4] ? -$signed({1'b0, b_mag5}) : $signed({1'b0, b_mag5});

      result <= sat48(a_val + b_val);
    end
  end

endmodule

// ===== rtl/simpson_weighted_complex_correlator.sv =====
`timescale 1ns / 1ps
// Simpson weighted complex correlator, top level.
// Throughput: one item per cycle while item_stall is low; a result follows capture and scaling.
// Rate is set by the single multiply-accumulate path: product, weighting, 48-bit accumulate.
// A stalled result freezes the 8-deep scaling pipeline; items keep flowing until a closing
// item reaches the accumulator while it is frozen. Synchronous reset clears sums, index,
// valids; config to defaults. Depends on swcc_pkg and swcc_finish.
module simpson_weighted_complex_correlator
  import swcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int FinDepth = 8;

  function automatic logic signed [WProdW-1:0] weigh(input logic signed [ProdW-1:0] p,
                                                     input logic [2:0] w);
    logic signed [WProdW-1:0] e;
    logic signed [WProdW-1:0] r;
    e = WProdW'(p);
    case (w)
      3'd1:    r = e;
      3'd2:    r = e <<< 1;
      3'd3:    r = e + (e <<< 1);
      3'd4:    r = e <<< 2;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [CountW-1:0] sample_count;
  logic [StepW-1:0]  step_size;
  logic [CountW-1:0] sample_index;

  logic signed [AccW-1:0] simpson_sum_real, simpson_sum_imag;
  logic signed [AccW-1:0] tail_sum_real, tail_sum_imag;
  logic signed [AccW-1:0] simpson_sum_real_next, simpson_sum_imag_next;
  logic signed [AccW-1:0] tail_sum_real_next, tail_sum_imag_next;

  logic                    p_valid, p_last;
  logic signed [ProdW-1:0] p_real, p_imag;
  logic [2:0]              p_ws;
  logic [1:0]              p_wt;

  logic                     w_valid, w_last;
  logic signed [WProdW-1:0] ws_real, ws_imag, wt_real, wt_imag;

  logic signed [AccW-1:0] cap_s_real, cap_s_imag, cap_t_real, cap_t_imag;
  logic [FinDepth-1:0]    fin_valid;

  logic item_fire, p_ready, w_ready, acc_fire, fin_en;

  logic [CountW-1:0] n_eff, n_m1, m, idx;
  logic              last;
  logic [2:0]        ws;
  logic [1:0]        wt;

  always_comb begin
    if (sample_count < MinCount) begin
      n_eff = MinCount;
    end else if (sample_count > MaxCount) begin
      n_eff = MaxCount;
    end else begin
      n_eff = sample_count;
    end
    n_m1 = n_eff - CountW'(1);
    m    = n_eff - CountW'(4);
    last = (sample_index >= n_m1);
    idx  = last ? n_m1 : sample_index;
    ws   = 3'd0;
    wt   = 2'd0;
    if (n_eff[0]) begin
      if (idx == '0 || idx == n_m1) begin
        ws = 3'd1;
      end else begin
        ws = idx[0] ? 3'd4 : 3'd2;
      end
    end else if (idx < m) begin
      if (idx == '0) begin
        ws = 3'd1;
      end else begin
        ws = idx[0] ? 3'd4 : 3'd2;
      end
    end else if (idx == m) begin
      ws = (m != '0) ? 3'd1 : 3'd0;
      wt = 2'd1;
    end else if (idx <= m + CountW'(2)) begin
      wt = 2'd3;
    end else begin
      wt = 2'd1;
    end
  end

  assign fin_en     = !fin_valid[FinDepth-1] || !result_stall;
  assign acc_fire   = w_valid && (!w_last || fin_en);
  assign w_ready    = !w_valid || acc_fire;
  assign p_ready    = !p_valid || w_ready;
  assign item_stall = !p_ready;
  assign item_fire  = item_valid && p_ready;
  assign cfg_ready  = 1'b1;

  always_comb begin
    simpson_sum_real_next = sat48({simpson_sum_real[AccW-1], simpson_sum_real}
                                  + (AccW+1)'(ws_real));
    simpson_sum_imag_next = sat48({simpson_sum_imag[AccW-1], simpson_sum_imag}
                                  + (AccW+1)'(ws_imag));
    tail_sum_real_next    = sat48({tail_sum_real[AccW-1], tail_sum_real}
                                  + (AccW+1)'(wt_real));
    tail_sum_imag_next    = sat48({tail_sum_imag[AccW-1], tail_sum_imag}
                                  + (AccW+1)'(wt_imag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= CountReset;
      step_size        <= StepReset;
      sample_index     <= '0;
      p_valid          <= 1'b0;
      w_valid          <= 1'b0;
      fin_valid        <= '0;
      simpson_sum_real <= '0;
      simpson_sum_imag <= '0;
      tail_sum_real    <= '0;
      tail_sum_imag    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CfgSampleCount: sample_count <= cfg_data[CountW-1:0];
          CfgStepSize:    step_size    <= cfg_data[StepW-1:0];
        endcase
      end
      if (item_fire) begin
        sample_index <= last ? '0 : sample_index + CountW'(1);
      end
      if (p_ready) begin
        p_valid <= item_valid;
      end
      if (w_ready) begin
        w_valid <= p_valid;
      end
      if (acc_fire) begin
        if (w_last) begin
          simpson_sum_real <= '0;
          simpson_sum_imag <= '0;
          tail_sum_real    <= '0;
          tail_sum_imag    <= '0;
        end else begin
          simpson_sum_real <= simpson_sum_real_next;
          simpson_sum_imag <= simpson_sum_imag_next;
          tail_sum_real    <= tail_sum_real_next;
          tail_sum_imag    <= tail_sum_imag_next;
        end
      end
      if (fin_en) begin
        fin_valid <= {fin_valid[FinDepth-2:0], acc_fire && w_last};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      p_real <= ProdW'(item.sample_value) * ProdW'(item.wavelet_real);
      p_imag <= ProdW'(item.sample_value) * ProdW'(item.wavelet_imag);
      p_ws   <= ws;
      p_wt   <= wt;
      p_last <= last;
    end
    if (p_valid && w_ready) begin
      ws_real <= weigh(p_real, p_ws);
      ws_imag <= weigh(p_imag, p_ws);
      wt_real <= weigh(p_real, {1'b0, p_wt});
      wt_imag <= weigh(p_imag, {1'b0, p_wt});
      w_last  <= p_last;
    end
    if (fin_en && acc_fire && w_last) begin
      cap_s_real <= simpson_sum_real_next;
      cap_s_imag <= simpson_sum_imag_next;
      cap_t_real <= tail_sum_real_next;
      cap_t_imag <= tail_sum_imag_next;
    end
  end

  swcc_finish u_finish_real (
    .clk    (clk),
    .en     (fin_en),
    .s_sum  (cap_s_real),
    .t_sum  (cap_t_real),
    .step   (step_size),
    .result (result.integral_real)
  );

  swcc_finish u_finish_imag (
    .clk    (clk),
    .en     (fin_en),
    .s_sum  (cap_s_imag),
    .t_sum  (cap_t_imag),
    .step   (step_size),
    .result (result.integral_imag)
  );

  assign result_valid = fin_valid[FinDepth-1];

endmodule

// ===== dv/simpson_weighted_complex_correlator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for simpson_weighted_complex_correlator: streams samples and wavelet
// values, predicts each complex Simpson integral in-line and checks every result transfer.
// Depends on swcc_pkg and the correlator RTL.
module simpson_weighted_complex_correlator_tb;
  import swcc_pkg::*;

  localparam longint AccHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccLo = -AccHi - 1;
  localparam int SettleCycles = 20;
  localparam int LongRun = 401;
  localparam logic [SampleBits-1:0] QMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [SampleBits-1:0] QMax = {1'b0, {(SampleBits-1){1'b1}}};

  typedef enum int {StyleFull, StyleCorner, StyleTiny} value_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgSampleCount;
  logic [CfgDataW-1:0] cfg_data = '0;

  simpson_weighted_complex_correlator dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CountW-1:0] count_reg = CountReset;
  logic [StepW-1:0] step_reg = StepReset;
  int unsigned point_index = 0;
  longint simpson_real = 0;
  longint simpson_imag = 0;
  longint tail_real = 0;
  longint tail_imag = 0;

  result_t expected_integrals[$];
  item_t sample_feed[$];
  result_t want_integral;

  int items_pushed = 0;
  int items_sent = 0;
  int integrals_predicted = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_request = 0;
  int stall_len;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  function automatic longint clamp_acc(input longint v);
    if (v > AccHi) return AccHi;
    if (v < AccLo) return AccLo;
    return v;
  endfunction

  function automatic void point_weights(input int unsigned idx, input int unsigned n,
                                        output longint ws, output longint wt);
    int unsigned m;
    ws = 0;
    wt = 0;
    if (n % 2 == 1) begin
      if (idx == 0 || idx == n - 1) ws = 1;
      else ws = (idx % 2 == 1) ? 4 : 2;
    end else begin
      m = n - 4;
      if (idx < m) begin
        ws = (idx == 0) ? 1 : ((idx % 2 == 1) ? 4 : 2);
      end else if (idx == m) begin
        ws = (m > 0) ? 1 : 0;
        wt = 1;
      end else if (idx <= m + 2) begin
        wt = 3;
      end else begin
        wt = 1;
      end
    end
  endfunction

  // h/3 on the 1/3-rule sum plus 3h/8 on the tail sum, magnitudes truncated
  function automatic longint scale_integral(input longint s, input longint t,
                                            input logic [StepW-1:0] h);
    longint unsigned ms, mt;
    longint a, b;
    ms = (s < 0) ? -s : s;
    mt = (t < 0) ? -t : t;
    ms = ms * h;
    mt = mt * h;
    a = ms / 64'd196608;
    b = 3 * (mt >> 19) + ((3 * (mt & 64'h7FFFF)) >> 19);
    if (s < 0) a = -a;
    if (t < 0) b = -b;
    return clamp_acc(a + b);
  endfunction

  task automatic predict_integral(input item_t it);
    int unsigned n, idx;
    bit closing;
    longint x, p, q, ws, wt, v;
    result_t r;
    n = count_reg;
    if (n < MinCount) n = MinCount;
    if (n > MaxSamples) n = MaxSamples;
    idx = point_index;
    closing = (idx >= n - 1);
    if (closing) idx = n - 1;
    x = longint'($signed(it.sample_value));
    p = x * longint'($signed(it.wavelet_real));
    q = x * longint'($signed(it.wavelet_imag));
    point_weights(idx, n, ws, wt);
    simpson_real = clamp_acc(simpson_real + ws * p);
    simpson_imag = clamp_acc(simpson_imag + ws * q);
    tail_real = clamp_acc(tail_real + wt * p);
    tail_imag = clamp_acc(tail_imag + wt * q);
    if (!closing) begin
      point_index++;
    end else begin
      v = scale_integral(simpson_real, tail_real, step_reg);
      r.integral_real = v[AccW-1:0];
      v = scale_integral(simpson_imag, tail_imag, step_reg);
      r.integral_imag = v[AccW-1:0];
      expected_integrals.push_back(r);
      integrals_predicted++;
      point_index = 0;
      simpson_real = 0;
      simpson_imag = 0;
      tail_real = 0;
      tail_imag = 0;
    end
  endtask

  function automatic int sender_gap();
    int r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int receiver_stall();
    int r;
    if (!receiver_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  // sender: advance to the next pending item once the current one transfers
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_integral(item);
        items_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (sample_feed.size() > 0) begin
          item <= sample_feed.pop_front();
          item_valid <= 1'b1;
          send_gap = sender_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_integrals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected integral re=%0d im=%0d", $realtime,
                     result.integral_real, result.integral_imag);
        end else begin
          want_integral = expected_integrals.pop_front();
          results_checked++;
          if (result.integral_real !== want_integral.integral_real ||
              result.integral_imag !== want_integral.integral_imag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: integral mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                       $realtime, want_integral.integral_real, want_integral.integral_imag,
                       result.integral_real, result.integral_imag);
          end
        end
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        stall_len = receiver_stall();
        if (stall_len > 0) begin
          stall_left = stall_len - 1;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [SampleBits-1:0] pick_value(input value_style_t st);
    logic [31:0] v;
    v = $urandom;
    case (st)
      StyleCorner: begin
        case (v[1:0])
          2'd0: return QMin;
          2'd1: return QMax;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      StyleTiny: return SampleBits'($signed(v[4:0]));
      default: return v[SampleBits-1:0];
    endcase
  endfunction

  function automatic item_t trio(input logic [SampleBits-1:0] s, input logic [SampleBits-1:0] wr,
                                 input logic [SampleBits-1:0] wi);
    return {s, wr, wi};
  endfunction

  function automatic item_t make_item(input value_style_t st);
    return trio(pick_value(st), pick_value(st), pick_value(st));
  endfunction

  function automatic logic [StepW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return StepW'(1);
      2: return '1;
      default: return StepW'($urandom);
    endcase
  endfunction

  task automatic queue_item(input item_t it);
    sample_feed.push_back(it);
    items_pushed++;
  endtask

  task automatic queue_random(input int unsigned cnt);
    int unsigned sel;
    repeat (cnt) begin
      sel = $urandom_range(0, 9);
      queue_item(make_item(sel < 7 ? StyleFull : (sel < 9 ? StyleCorner : StyleTiny)));
    end
  endtask

  // hold until every queued item has transferred and every integral has arrived
  task automatic wait_drained();
    do @(posedge clk);
    while (items_sent != items_pushed || expected_integrals.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgSampleCount) count_reg = data[CountW-1:0];
    else step_reg = data[StepW-1:0];
    cfg_writes++;
  endtask

  initial begin
    #20_000_000;
    $display("** simpson_weighted_complex_correlator: FAILED **");
    $finish;
  end

  initial begin
    int unsigned count_val, eff, cnt;
    int random_items;
    logic [CfgDataW-1:0] cfg_word;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, largest count rewritten, then shrink it mid-integration
    write_reg(CfgSampleCount, CfgDataW'(MaxSamples));
    queue_item(trio(QMax, QMax, QMax));
    queue_item(trio(QMin, QMin, QMin));
    queue_item(trio(QMin, QMax, QMin));
    write_reg(CfgSampleCount, CfgDataW'(5));
    queue_item(trio(QMax, QMin, QMax));
    queue_item(trio(SampleBits'(1), QMax, QMin));

    write_reg(CfgStepSize, '1);
    write_reg(CfgSampleCount, CfgDataW'(3));
    queue_item(trio(QMin, QMin, QMin));
    queue_item(trio(QMin, QMin, QMax));
    queue_item(trio(QMax, QMax, QMin));

    write_reg(CfgSampleCount, CfgDataW'(4));
    repeat (4) queue_item(make_item(StyleCorner));
    write_reg(CfgSampleCount, CfgDataW'(6));
    repeat (6) queue_item(make_item(StyleFull));

    write_reg(CfgStepSize, '0);
    write_reg(CfgSampleCount, '0);
    repeat (3) queue_item(make_item(StyleFull));

    // drop the count below the current index: next item closes
    write_reg(CfgStepSize, StepW'(1));
    write_reg(CfgSampleCount, CfgDataW'(9));
    repeat (5) queue_item(make_item(StyleFull));
    write_reg(CfgSampleCount, CfgDataW'(3));
    queue_item(make_item(StyleCorner));

    // receiver holds off while short integrations pile up behind it
    write_reg(CfgStepSize, pick_step());
    sender_idles = 1'b0;
    receiver_idles = 1'b1;
    hold_request = 400;
    queue_random(90);
    random_items += 90;
    wait_drained();
    sender_idles = 1'b1;
    queue_random(30);
    random_items += 30;

    while (random_items < 1000) begin
      case ($urandom_range(0, 99)) inside
        [0:69]: count_val = $urandom_range(3, 24);
        [70:84]: count_val = $urandom_range(25, 200);
        [85:92]: count_val = $urandom_range(0, 2);
        default: count_val = $urandom_range(MaxSamples - 8, (1 << CountW) - 1);
      endcase
      cfg_word = CfgDataW'($urandom);
      cfg_word[CountW-1:0] = count_val[CountW-1:0];
      write_reg(CfgSampleCount, cfg_word);
      if ($urandom_range(0, 1) == 1) write_reg(CfgStepSize, pick_step());
      eff = (count_val < 3) ? 3 : ((count_val > MaxSamples) ? MaxSamples : count_val);
      if (eff > 200) begin
        cnt = $urandom_range(5, 60);
      end else begin
        cnt = eff * $urandom_range(1, (eff <= 24) ? 4 : 1);
        if ($urandom_range(0, 3) == 0) cnt += $urandom_range(1, eff - 1);
      end
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      queue_random(cnt);
      random_items += cnt;
    end

    // close any open integration, then one long run at the largest magnitudes
    write_reg(CfgSampleCount, CfgDataW'(3));
    while (point_index != 0) begin
      queue_item(make_item(StyleFull));
      wait_drained();
    end
    write_reg(CfgSampleCount, CfgDataW'(LongRun));
    write_reg(CfgStepSize, '1);
    sender_idles = 1'b0;
    receiver_idles = 1'b1;
    repeat (LongRun)
      queue_item(trio(QMin, ($urandom_range(0, 1) == 1) ? QMin : QMax,
                      ($urandom_range(0, 1) == 1) ? QMin : QMax));

    wait_drained();
    $display("Covered %0d sample transfers, %0d integrals checked, %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Counts from below the minimum to past the maximum, steps 0 to full scale.");
    if (mismatches == 0) begin
      $display("** simpson_weighted_complex_correlator: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** simpson_weighted_complex_correlator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swcc_pkg.sv
rtl/swcc_finish.sv
rtl/simpson_weighted_complex_correlator.sv
dv/simpson_weighted_complex_correlator_tb.sv
